// ----- design/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// Widths, limits and carried-side types for the pairwise repulsion pipeline.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned Lanes   = 4;
  localparam int unsigned PosW    = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned MassW   = 32;
  localparam int unsigned KW      = 16;
  localparam int unsigned OutW    = 48;

  localparam int unsigned MagW    = PosW;
  localparam int unsigned SqW     = 2 * MagW;
  localparam int unsigned RootW   = SqW / 2;
  localparam int unsigned RemW    = RootW + 2;
  localparam int unsigned DenW    = SqW + RootW;
  localparam int unsigned PmW     = MassW + MagW;
  localparam int unsigned PkW     = PmW / 2 + KW + 1;
  localparam int unsigned NumW    = PmW + KW + 1;
  localparam int unsigned QW      = OutW + 1;
  localparam int unsigned FracSh  = 40;
  localparam int unsigned LowBits = QW - FracSh;
  localparam int unsigned HiW     = NumW - LowBits;

  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned DivSteps  = QW;

  localparam logic [OutW-1:0] OutPosMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] OutNegMin = {1'b1, {(OutW-1){1'b0}}};
  localparam logic [QW-1:0]   QPosMax   = {2'b00, {(OutW-1){1'b1}}};
  localparam logic [QW-1:0]   QNegMag   = {2'b01, {(OutW-1){1'b0}}};
  localparam logic [QW-1:0]   QSat      = {1'b1, {(QW-1){1'b0}}};

  typedef logic [NumW-1:0] num_t;

  typedef struct packed {
    logic                   ovl;
    logic [Lanes-1:0]       neg;
    logic [Lanes-1:0][NumW-1:0] num;
  } side_t;

endpackage

// ----- design/pairwise_repulsion_force.sv -----
// ----------------------------------------------------------------------------
// pairwise_repulsion_force
// Inverse-square repulsion deltas for one particle pair per clock: offset,
// squared length, pipelined integer sqrt, S*sqrt(S) and four pipelined
// long dividers with saturation to Q8.40.
// ----------------------------------------------------------------------------
// channel   | direction | transfer
// ----------+-----------+---------------------------------------------------
// command   | in        | start_i high while busy_o low; pair on *_pos/radius/mass
// result    | out       | done_o high for one cycle with deltas and overlapping_o
// config    | in        | cfg_we_i high writes cfg_wdata_i into strength k
//
// One pair enters every cycle; its result strobes on done_o once it has passed stages A to H.
// Most of the pipeline depth is in the 32-step sqrt pipeline and the 49-step divider pipeline.
// busy_o is always low; the result side cannot stall, so no stage ever holds.
// Reset clears the valid bits and k; payload registers are not reset.
module pairwise_repulsion_force (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             cfg_we_i,
  input  logic        [prc_pkg::KW-1:0]    cfg_wdata_i,
  input  logic signed [prc_pkg::PosW-1:0]  a_pos_x_i,
  input  logic signed [prc_pkg::PosW-1:0]  a_pos_y_i,
  input  logic signed [prc_pkg::PosW-1:0]  b_pos_x_i,
  input  logic signed [prc_pkg::PosW-1:0]  b_pos_y_i,
  input  logic        [prc_pkg::RadW-1:0]  a_radius_i,
  input  logic        [prc_pkg::RadW-1:0]  b_radius_i,
  input  logic        [prc_pkg::MassW-1:0] a_mass_i,
  input  logic        [prc_pkg::MassW-1:0] b_mass_i,
  output logic                             done_o,
  output logic signed [prc_pkg::OutW-1:0]  a_acc_dx_o,
  output logic signed [prc_pkg::OutW-1:0]  a_acc_dy_o,
  output logic signed [prc_pkg::OutW-1:0]  b_acc_dx_o,
  output logic signed [prc_pkg::OutW-1:0]  b_acc_dy_o,
  output logic                             overlapping_o
);

  localparam int unsigned L  = prc_pkg::Lanes;
  localparam int unsigned NS = prc_pkg::SqrtSteps;
  localparam int unsigned ND = prc_pkg::DivSteps;

  assign busy_o = 1'b0;

  // strength register
  logic signed [prc_pkg::KW-1:0] k_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  // stage A: offsets
  logic signed [prc_pkg::PosW:0]   dx_d, dy_d;
  logic        [prc_pkg::MagW-1:0] adx_d, ady_d;
  logic        [prc_pkg::MagW-1:0] rsum_d;
  assign dx_d   = (prc_pkg::PosW+1)'(b_pos_x_i) - (prc_pkg::PosW+1)'(a_pos_x_i);
  assign dy_d   = (prc_pkg::PosW+1)'(b_pos_y_i) - (prc_pkg::PosW+1)'(a_pos_y_i);
  assign adx_d  = dx_d[prc_pkg::PosW] ? prc_pkg::MagW'(-dx_d) : dx_d[prc_pkg::MagW-1:0];
  assign ady_d  = dy_d[prc_pkg::PosW] ? prc_pkg::MagW'(-dy_d) : dy_d[prc_pkg::MagW-1:0];
  assign rsum_d = prc_pkg::MagW'(a_radius_i) + prc_pkg::MagW'(b_radius_i);

  logic                        a_v_q;
  logic [prc_pkg::MagW-1:0]    a_adx_q, a_ady_q, a_rsum_q;
  logic                        a_xn_q, a_yn_q;
  logic [prc_pkg::MassW-1:0]   a_ma_q, a_mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_adx_q  <= adx_d;
    a_ady_q  <= ady_d;
    a_rsum_q <= rsum_d;
    a_xn_q   <= dx_d[prc_pkg::PosW];
    a_yn_q   <= dy_d[prc_pkg::PosW];
    a_ma_q   <= a_mass_i;
    a_mb_q   <= b_mass_i;
  end

  // stage B: squares and mass * offset products
  logic                                b_v_q;
  logic [prc_pkg::SqW-1:0]             b_sqx_q, b_sqy_q, b_rsq_q;
  logic [L-1:0][prc_pkg::PmW-1:0]      b_pm_q;
  logic                                b_xn_q, b_yn_q;
  logic [L-1:0][prc_pkg::PmW-1:0]      pm_d;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      pm_d[i] = prc_pkg::PmW'(i < 2 ? a_mb_q : a_ma_q)
              * prc_pkg::PmW'(i[0] ? a_ady_q : a_adx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_sqx_q <= prc_pkg::SqW'(a_adx_q) * prc_pkg::SqW'(a_adx_q);
    b_sqy_q <= prc_pkg::SqW'(a_ady_q) * prc_pkg::SqW'(a_ady_q);
    b_rsq_q <= prc_pkg::SqW'(a_rsum_q) * prc_pkg::SqW'(a_rsum_q);
    b_pm_q  <= pm_d;
    b_xn_q  <= a_xn_q;
    b_yn_q  <= a_yn_q;
  end

  // stage C: squared length, overlap test, strength partials
  logic [prc_pkg::SqW:0]          s_full_d;
  logic [prc_pkg::KW-1:0]         kmag_d;
  logic [prc_pkg::KW:0]           k2_d;
  logic                           xneg_d, yneg_d;
  logic [L-1:0][prc_pkg::PkW-1:0] pklo_d, pkhi_d;

  assign s_full_d = (prc_pkg::SqW+1)'(b_sqx_q) + (prc_pkg::SqW+1)'(b_sqy_q);
  assign kmag_d   = k_q[prc_pkg::KW-1] ? prc_pkg::KW'(-k_q) : k_q;
  assign k2_d     = {kmag_d, 1'b0};
  assign xneg_d   = k_q[prc_pkg::KW-1] ^ b_xn_q;
  assign yneg_d   = k_q[prc_pkg::KW-1] ^ b_yn_q;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      pklo_d[i] = prc_pkg::PkW'(b_pm_q[i][prc_pkg::PmW/2-1:0]) * prc_pkg::PkW'(k2_d);
      pkhi_d[i] = prc_pkg::PkW'(b_pm_q[i][prc_pkg::PmW-1:prc_pkg::PmW/2])
                * prc_pkg::PkW'(k2_d);
    end
  end

  logic                           c_v_q;
  logic [prc_pkg::SqW-1:0]        c_s_q;
  logic                           c_ovl_q;
  logic [L-1:0]                   c_neg_q;
  logic [L-1:0][prc_pkg::PkW-1:0] c_pklo_q, c_pkhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_s_q    <= s_full_d[prc_pkg::SqW-1:0];
    c_ovl_q  <= (s_full_d != '0) && (s_full_d < (prc_pkg::SqW+1)'(b_rsq_q));
    c_neg_q  <= {yneg_d, xneg_d, ~yneg_d, ~xneg_d};
    c_pklo_q <= pklo_d;
    c_pkhi_q <= pkhi_d;
  end

  // stage D: numerators, sqrt entry
  logic                    sq_v_q    [0:NS];
  logic [prc_pkg::RemW-1:0]  sq_rem_q  [0:NS];
  logic [prc_pkg::RootW-1:0] sq_root_q [0:NS];
  logic [prc_pkg::SqW-1:0]   sq_s_q    [0:NS];
  prc_pkg::side_t          sq_side_q [0:NS];
  prc_pkg::side_t          side_d;

  always_comb begin
    side_d.ovl = c_ovl_q;
    side_d.neg = c_neg_q;
    for (int i = 0; i < L; i++) begin
      side_d.num[i] = {c_pkhi_q[i], {(prc_pkg::PmW/2){1'b0}}}
                    + prc_pkg::NumW'(c_pklo_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_s_q[0]    <= c_s_q;
    sq_side_q[0] <= side_d;
  end

  // integer sqrt, two radicand bits per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int unsigned Hi = prc_pkg::SqW - 1 - 2 * k;
    logic [prc_pkg::RemW+1:0]  rem_sh, trial;
    logic                      ge;
    logic [prc_pkg::RemW-1:0]  rem_n;
    logic [prc_pkg::RootW-1:0] root_n;

    assign rem_sh = {sq_rem_q[k], sq_s_q[k][Hi -: 2]};
    assign trial  = (prc_pkg::RemW+2)'({sq_root_q[k], 2'b01});
    assign ge     = rem_sh >= trial;
    assign rem_n  = ge ? prc_pkg::RemW'(rem_sh - trial) : rem_sh[prc_pkg::RemW-1:0];
    assign root_n = {sq_root_q[k][prc_pkg::RootW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[k+1]  <= rem_n;
      sq_root_q[k+1] <= root_n;
      sq_s_q[k+1]    <= sq_s_q[k];
      sq_side_q[k+1] <= sq_side_q[k];
    end
  end

  // stage E: S * root partial products
  logic                    e_v_q;
  logic [prc_pkg::SqW-1:0] e_plo_q, e_phi_q;
  prc_pkg::side_t          e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else begin
      e_v_q <= sq_v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    e_plo_q  <= prc_pkg::SqW'(sq_s_q[NS][prc_pkg::SqW/2-1:0])
              * prc_pkg::SqW'(sq_root_q[NS]);
    e_phi_q  <= prc_pkg::SqW'(sq_s_q[NS][prc_pkg::SqW-1:prc_pkg::SqW/2])
              * prc_pkg::SqW'(sq_root_q[NS]);
    e_side_q <= sq_side_q[NS];
  end

  // stage F: denominator
  logic                     f_v_q;
  logic [prc_pkg::DenW-1:0] f_den_q;
  prc_pkg::side_t           f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_den_q  <= {e_phi_q, {(prc_pkg::SqW/2){1'b0}}} + prc_pkg::DenW'(e_plo_q);
    f_side_q <= e_side_q;
  end

  // stage G: divider entry, early saturation on the high part
  logic                               dv_v_q    [0:ND];
  logic [L-1:0][prc_pkg::DenW-1:0]    dv_rem_q  [0:ND];
  logic [L-1:0][prc_pkg::QW-1:0]      dv_q_q    [0:ND];
  logic [L-1:0]                       dv_sat_q  [0:ND];
  logic [prc_pkg::DenW-1:0]           dv_den_q  [0:ND];
  prc_pkg::side_t                     dv_side_q [0:ND];
  logic [L-1:0][prc_pkg::DenW-1:0]    hi_d;
  logic [L-1:0]                       sat_d;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      hi_d[i]  = prc_pkg::DenW'(f_side_q.num[i][prc_pkg::NumW-1:prc_pkg::LowBits]);
      sat_d[i] = hi_d[i] >= f_den_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < L; i++) begin
      dv_rem_q[0][i] <= sat_d[i] ? '0 : hi_d[i];
    end
    dv_q_q[0]    <= '0;
    dv_sat_q[0]  <= sat_d;
    dv_den_q[0]  <= f_den_q;
    dv_side_q[0] <= f_side_q;
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [L-1:0][prc_pkg::DenW-1:0] rem_n;
    logic [L-1:0][prc_pkg::QW-1:0]   q_n;

    for (genvar i = 0; i < L; i++) begin : g_lane
      logic                   nb;
      logic [prc_pkg::DenW:0] rem_sh, den_x;
      logic                   ge;

      if (j < prc_pkg::LowBits) begin : g_nb
        assign nb = dv_side_q[j].num[i][prc_pkg::LowBits-1-j];
      end else begin : g_zero
        assign nb = 1'b0;
      end

      assign rem_sh   = {dv_rem_q[j][i], nb};
      assign den_x    = (prc_pkg::DenW+1)'(dv_den_q[j]);
      assign ge       = rem_sh >= den_x;
      assign rem_n[i] = ge ? prc_pkg::DenW'(rem_sh - den_x) : rem_sh[prc_pkg::DenW-1:0];
      assign q_n[i]   = {dv_q_q[j][i][prc_pkg::QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[j+1]  <= rem_n;
      dv_q_q[j+1]    <= q_n;
      dv_sat_q[j+1]  <= dv_sat_q[j];
      dv_den_q[j+1]  <= dv_den_q[j];
      dv_side_q[j+1] <= dv_side_q[j];
    end
  end

  // stage H: sign, saturation, output register
  logic [L-1:0][prc_pkg::OutW-1:0] res_d;
  logic [prc_pkg::QW-1:0]          mag;

  always_comb begin
    res_d = '0;
    mag   = '0;
    for (int i = 0; i < L; i++) begin
      mag = dv_sat_q[ND][i] ? prc_pkg::QSat : dv_q_q[ND][i];
      if (!dv_side_q[ND].ovl) begin
        res_d[i] = '0;
      end else if (dv_side_q[ND].neg[i]) begin
        res_d[i] = (mag > prc_pkg::QNegMag) ? prc_pkg::OutNegMin
                                            : prc_pkg::OutW'(prc_pkg::QW'(0) - mag);
      end else begin
        res_d[i] = (mag > prc_pkg::QPosMax) ? prc_pkg::OutPosMax
                                            : mag[prc_pkg::OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv_v_q[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    a_acc_dx_o    <= res_d[0];
    a_acc_dy_o    <= res_d[1];
    b_acc_dx_o    <= res_d[2];
    b_acc_dy_o    <= res_d[3];
    overlapping_o <= dv_side_q[ND].ovl;
  end

endmodule
